// ----- sv/bhd_pkg.sv -----
// Package with shared types and constants of the button event and hold detector.
package bhd_pkg;

  // Number of tracked buttons: two real ones and the virtual any-button
  localparam int unsigned NUM_BTN = 3;
  localparam int unsigned ANY_IDX = 2;

  // Event bit positions inside one button's event field
  localparam int unsigned EV_DOWN_BIT = 0;
  localparam int unsigned EV_UP_BIT   = 1;
  localparam int unsigned EV_HOLD_BIT = 2;

  // Hold time register
  localparam int unsigned HOLD_W           = 16;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd1000;

  // Configuration port geometry and register map
  localparam int unsigned CFG_AW         = 3;
  localparam int unsigned CFG_DW         = 32;
  localparam logic [CFG_AW-1:0] ADDR_HOLD_TICKS = 3'd0;

  typedef logic [NUM_BTN-1:0] btn_vec_t;
  typedef logic [2:0]         ev_bits_t;
  typedef logic [HOLD_W-1:0]  hold_cnt_t;

  // Item function codes
  typedef enum logic [1:0] {
    FUNC_LEVEL = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_TAKE  = 2'd2
  } func_t;

endpackage

// ----- sv/bhd_in_if.sv -----
// Input item channel of the button event and hold detector.
interface bhd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic       button_index;
  logic       level;

  modport source (output valid, output func, output button_index, output level,
                  input ready);
  modport sink (input valid, input func, input button_index, input level,
                output ready);
endinterface

// ----- sv/bhd_out_if.sv -----
// Result item channel of the button event and hold detector.
interface bhd_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [2:0] levels;
  logic [2:0] events_btn0;
  logic [2:0] events_btn1;
  logic [2:0] events_any;
  logic       pending_flag;

  modport source (output valid, output accepted, output levels, output events_btn0,
                  output events_btn1, output events_any, output pending_flag,
                  input ready);
  modport sink (input valid, input accepted, input levels, input events_btn0,
                input events_btn1, input events_any, input pending_flag,
                output ready);
endinterface

// ----- sv/button_event_hold_detector.sv -----
// Top level of the button event and hold detector: input register, update logic, result register.
// An accepted item is held in the input register and moves into the result register when that register is free.
// Throughput: one item per cycle while the result side does not stall; the single input register and the result
// register decouple the two sides, so a new item can enter while a result waits to be taken.
// Reset: synchronous active-low rst_n clears levels, events, timers, pending and both
// valid flags, and loads hold_ticks with 1000.
module button_event_hold_detector
  import bhd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  bhd_in_if.sink            in_ch,
  bhd_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // Configuration
  hold_cnt_t hold_ticks_r;

  // Input register
  logic       in_valid_r;
  func_t      in_func_r;
  logic       in_idx_r;
  logic       in_lvl_r;

  // Detector state
  btn_vec_t  levels_r, levels_nxt;
  ev_bits_t  ev_r [NUM_BTN];
  ev_bits_t  ev_nxt [NUM_BTN];
  hold_cnt_t cnt_r [NUM_BTN];
  hold_cnt_t cnt_nxt [NUM_BTN];
  btn_vec_t  armed_r, armed_nxt;
  logic      pend_r, pend_nxt;

  // Result register
  logic      out_valid_r;
  logic      acc_r, acc_nxt;
  ev_bits_t  res_ev_r [NUM_BTN];
  ev_bits_t  res_ev_nxt [NUM_BTN];

  logic      advance;
  hold_cnt_t hold_eff;
  btn_vec_t  chg;
  logic      any_lvl;

  // Move the held item into the result register when that register frees up
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_HOLD_TICKS) ?
                      {{(CFG_DW-HOLD_W){1'b0}}, hold_ticks_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r <= HOLD_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_HOLD_TICKS) begin
      hold_ticks_r <= cfg_pwdata[HOLD_W-1:0];
    end
  end

  // Hold an accepted item until it is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_func_r <= func_t'(in_ch.func);
      in_idx_r  <= in_ch.button_index;
      in_lvl_r  <= in_ch.level;
    end
  end

  // Zero hold time counts as one tick
  assign hold_eff = (hold_ticks_r == '0) ? hold_cnt_t'(1) : hold_ticks_r;

  // Compute next state and result for the held item
  always_comb begin
    levels_nxt = levels_r;
    armed_nxt  = armed_r;
    pend_nxt   = pend_r;
    acc_nxt    = 1'b0;
    chg        = '0;
    any_lvl    = 1'b0;
    for (int k = 0; k < NUM_BTN; k++) begin
      ev_nxt[k]     = ev_r[k];
      cnt_nxt[k]    = cnt_r[k];
      res_ev_nxt[k] = '0;
    end

    case (in_func_r)
      FUNC_LEVEL: begin
        // Real buttons: only the addressed one can change
        for (int k = 0; k < ANY_IDX; k++) begin
          chg[k] = (in_idx_r == k[0]) && (levels_r[k] != in_lvl_r);
          if (chg[k]) levels_nxt[k] = in_lvl_r;
        end
        any_lvl      = |levels_nxt[ANY_IDX-1:0];
        chg[ANY_IDX] = (|chg[ANY_IDX-1:0]) && (levels_r[ANY_IDX] != any_lvl);
        if (chg[ANY_IDX]) levels_nxt[ANY_IDX] = any_lvl;
        // Latch edge events and arm or disarm the timers
        for (int k = 0; k < NUM_BTN; k++) begin
          if (chg[k]) begin
            if (levels_nxt[k]) begin
              ev_nxt[k][EV_DOWN_BIT] = 1'b1;
              cnt_nxt[k]             = hold_eff;
              armed_nxt[k]           = 1'b1;
            end else begin
              ev_nxt[k][EV_UP_BIT] = 1'b1;
              cnt_nxt[k]           = '0;
              armed_nxt[k]         = 1'b0;
            end
          end
        end
        if (|chg[ANY_IDX-1:0]) begin
          pend_nxt = 1'b1;
          acc_nxt  = 1'b1;
        end
      end
      FUNC_TICK: begin
        // Count down armed timers; expire at zero
        for (int k = 0; k < NUM_BTN; k++) begin
          if (armed_r[k]) begin
            if (cnt_r[k] != '0) cnt_nxt[k] = cnt_r[k] - hold_cnt_t'(1);
            if (cnt_nxt[k] == '0) begin
              armed_nxt[k]           = 1'b0;
              ev_nxt[k][EV_HOLD_BIT] = 1'b1;
              pend_nxt               = 1'b1;
            end
          end
        end
      end
      FUNC_TAKE: begin
        // Hand out and clear events only when some are pending
        if (pend_r) begin
          for (int k = 0; k < NUM_BTN; k++) begin
            res_ev_nxt[k] = ev_r[k];
            ev_nxt[k]     = '0;
          end
          pend_nxt = 1'b0;
          acc_nxt  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Commit state when the item advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r <= '0;
      armed_r  <= '0;
      pend_r   <= 1'b0;
      for (int k = 0; k < NUM_BTN; k++) begin
        ev_r[k]  <= '0;
        cnt_r[k] <= '0;
      end
    end else if (advance) begin
      levels_r <= levels_nxt;
      armed_r  <= armed_nxt;
      pend_r   <= pend_nxt;
      for (int k = 0; k < NUM_BTN; k++) begin
        ev_r[k]  <= ev_nxt[k];
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      acc_r <= acc_nxt;
      for (int k = 0; k < NUM_BTN; k++) res_ev_r[k] <= res_ev_nxt[k];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.accepted     = acc_r;
  assign out_ch.events_btn0  = res_ev_r[0];
  assign out_ch.events_btn1  = res_ev_r[1];
  assign out_ch.events_any   = res_ev_r[ANY_IDX];

  // Levels and pending are loaded together with the state on advance
  logic [2:0] res_lvl_r;
  logic       res_pend_r;
  always_ff @(posedge clk) begin
    if (advance) begin
      res_lvl_r  <= levels_nxt;
      res_pend_r <= pend_nxt;
    end
  end
  assign out_ch.levels       = res_lvl_r;
  assign out_ch.pending_flag = res_pend_r;

endmodule

// ----- sv/bhd_checker.sv -----
// Port-level checker of the button event and hold detector, bound to the top level.
module bhd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_accepted,
  input logic [2:0] out_levels,
  input logic [2:0] out_events_btn0,
  input logic [2:0] out_events_btn1,
  input logic [2:0] out_events_any,
  input logic       out_pending_flag
);

  logic ev_any_set;
  assign ev_any_set = (out_events_btn0 != 3'd0) || (out_events_btn1 != 3'd0) ||
                      (out_events_any != 3'd0);

  // Result channel is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result stays valid and keeps its levels, accepted and pending flags
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_levels) &&
      $stable(out_accepted) && $stable(out_pending_flag))
    else $error("stalled result changed");

  // Events are only reported by an accepted take, which leaves nothing pending
  a_events_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ev_any_set |-> out_accepted && !out_pending_flag)
    else $error("events reported outside an accepted take");

  // Any-button level is the OR of both real buttons
  a_any_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_levels[2] == (out_levels[0] | out_levels[1]))
    else $error("any-button level mismatch");

endmodule

bind button_event_hold_detector bhd_checker u_bhd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_accepted     (out_ch.accepted),
  .out_levels       (out_ch.levels),
  .out_events_btn0  (out_ch.events_btn0),
  .out_events_btn1  (out_ch.events_btn1),
  .out_events_any   (out_ch.events_any),
  .out_pending_flag (out_ch.pending_flag)
);

// ----- tb/sv/button_event_hold_detector_tb.sv -----
// Testbench for the button event and hold detector: directed and random items checked against a model.
module button_event_hold_detector_tb
  import bhd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 180;

  typedef struct packed {
    logic [1:0] fn;
    logic       idx;
    logic       lvl;
  } stim_t;

  typedef struct packed {
    logic     acc;
    btn_vec_t levels;
    ev_bits_t ev0;
    ev_bits_t ev1;
    ev_bits_t eva;
    logic     pend;
  } result_t;

  logic clk;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  bhd_in_if  in_ch ();
  bhd_out_if out_ch ();

  button_event_hold_detector DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Model state of the detector
  hold_cnt_t hold_ticks;
  btn_vec_t  levels_now;
  ev_bits_t  latched [NUM_BTN];
  hold_cnt_t hold_left [NUM_BTN];
  btn_vec_t  armed;
  logic      pending;

  // Stimulus and scoreboard bookkeeping
  stim_t   items_todo [$];
  result_t events_due [$];
  stim_t   cur;
  int      queued_cnt;
  int      accepted_cnt;
  int      fail_count;
  int      cycle_cnt;
  int      in_gap;
  int      out_gap;
  int      tick_span;
  bit      gaps_on;
  logic    in_taken;
  logic [1:0] gen_lvl;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Pick an idle length: mostly none, some short, a few long
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic note_fault(input string what, input int want, input int got);
    fail_count++;
    if (fail_count <= 10)
      $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
  endtask

  // Apply a level to one button of the model; return 1 when it changed
  function automatic logic apply_level(input int unsigned k, input logic v);
    if (levels_now[k] == v) return 1'b0;
    levels_now[k] = v;
    if (v) begin
      latched[k][EV_DOWN_BIT] = 1'b1;
      hold_left[k] = (hold_ticks == '0) ? hold_cnt_t'(1) : hold_ticks;
      armed[k] = 1'b1;
    end else begin
      latched[k][EV_UP_BIT] = 1'b1;
      hold_left[k] = '0;
      armed[k] = 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the model by one item and return the result it gives
  function automatic result_t button_events(input logic [1:0] fn, input logic idx,
                                            input logic lv);
    result_t r;
    r = '0;
    case (fn)
      FUNC_LEVEL: begin
        if (apply_level(idx, lv)) begin
          void'(apply_level(ANY_IDX, |levels_now[1:0]));
          pending = 1'b1;
          r.acc = 1'b1;
        end
      end
      FUNC_TICK: begin
        for (int k = 0; k < NUM_BTN; k++) begin
          if (armed[k]) begin
            if (hold_left[k] != '0) hold_left[k] = hold_left[k] - 1'b1;
            if (hold_left[k] == '0) begin
              armed[k] = 1'b0;
              latched[k][EV_HOLD_BIT] = 1'b1;
              pending = 1'b1;
            end
          end
        end
      end
      FUNC_TAKE: begin
        if (pending) begin
          r.ev0 = latched[0];
          r.ev1 = latched[1];
          r.eva = latched[ANY_IDX];
          for (int k = 0; k < NUM_BTN; k++) latched[k] = '0;
          pending = 1'b0;
          r.acc = 1'b1;
        end
      end
      default: ;
    endcase
    r.levels = levels_now;
    r.pend = pending;
    return r;
  endfunction

  // Drive input items at the falling edge, hold each until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else if (!in_ch.valid || in_taken) begin
      if (in_gap != 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (items_todo.size() != 0) begin
        cur = items_todo.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.func <= cur.fn;
        in_ch.button_index <= cur.idx;
        in_ch.level <= cur.lvl;
        in_gap = next_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(negedge clk) begin
    if (out_gap != 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      out_gap = next_gap();
    end
  end

  // Sample both channels at the rising edge: check results, predict new items
  always @(posedge clk) begin
    result_t got;
    result_t want;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (!rst_n) begin
      levels_now = '0;
      armed = '0;
      pending = 1'b0;
      for (int k = 0; k < NUM_BTN; k++) begin
        latched[k] = '0;
        hold_left[k] = '0;
      end
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.acc = out_ch.accepted;
        got.levels = out_ch.levels;
        got.ev0 = out_ch.events_btn0;
        got.ev1 = out_ch.events_btn1;
        got.eva = out_ch.events_any;
        got.pend = out_ch.pending_flag;
        if (events_due.size() == 0) begin
          note_fault("result with no item waiting", 0, got);
        end else begin
          want = events_due.pop_front();
          if (got.acc !== want.acc) note_fault("accepted", want.acc, got.acc);
          if (got.levels !== want.levels) note_fault("levels", want.levels, got.levels);
          if (got.ev0 !== want.ev0) note_fault("events_btn0", want.ev0, got.ev0);
          if (got.ev1 !== want.ev1) note_fault("events_btn1", want.ev1, got.ev1);
          if (got.eva !== want.eva) note_fault("events_any", want.eva, got.eva);
          if (got.pend !== want.pend) note_fault("pending_flag", want.pend, got.pend);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        events_due.push_back(button_events(in_ch.func, in_ch.button_index, in_ch.level));
        accepted_cnt++;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic add_item(input logic [1:0] fn, input logic idx, input logic lv);
    items_todo.push_back('{fn: fn, idx: idx, lvl: lv});
    queued_cnt++;
    if (fn == FUNC_LEVEL) gen_lvl[idx] = lv;
  endtask

  task automatic add_ticks(input int n);
    repeat (n) add_item(FUNC_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Press a button, let time pass, maybe touch the other one, maybe release and take; a held button is released
  task automatic add_press_cycle();
    logic b;
    b = 1'($urandom_range(0, 1));
    if (gen_lvl[b]) begin
      add_item(FUNC_LEVEL, b, 1'b0);
      if ($urandom_range(0, 99) < 60) add_item(FUNC_TAKE, 1'b0, 1'b0);
    end else begin
      add_item(FUNC_LEVEL, b, 1'b1);
      add_ticks($urandom_range(0, tick_span));
      if ($urandom_range(0, 99) < 30) add_item(FUNC_LEVEL, !b, !gen_lvl[!b]);
      if ($urandom_range(0, 99) < 40) add_ticks($urandom_range(0, tick_span));
      if ($urandom_range(0, 99) < 65) add_item(FUNC_LEVEL, b, 1'b0);
      if ($urandom_range(0, 99) < 70)
        add_item(FUNC_TAKE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic add_random(input int n);
    int target;
    target = queued_cnt + n;
    while (queued_cnt < target) begin
      if ($urandom_range(0, 99) < 70)
        add_press_cycle();
      else
        add_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    end
  endtask

  // Wait until every item is taken and every result checked
  task automatic wait_idle();
    while (accepted_cnt != queued_cnt || events_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [CFG_AW-1:0] addr,
                          input logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    if (wr && addr == ADDR_HOLD_TICKS) hold_ticks = wdata[HOLD_W-1:0];
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic check_hold_reg();
    logic [CFG_DW-1:0] rd;
    apb_xfer(1'b0, ADDR_HOLD_TICKS, '0, rd);
    if (rd !== CFG_DW'(hold_ticks)) note_fault("hold_ticks readback", hold_ticks, rd);
  endtask

  task automatic set_hold(input hold_cnt_t v);
    logic [CFG_DW-1:0] rd;
    apb_xfer(1'b1, ADDR_HOLD_TICKS, CFG_DW'(v), rd);
    check_hold_reg();
    tick_span = (v == '0) ? 2 : (v > 14) ? 16 : int'(v) + 2;
  endtask

  initial begin
    hold_cnt_t settings [8];
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_LEVEL;
    in_ch.button_index = 1'b0;
    in_ch.level = 1'b0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    hold_ticks = HOLD_RESET;
    queued_cnt = 0;
    accepted_cnt = 0;
    fail_count = 0;
    cycle_cnt = 0;
    in_gap = 0;
    out_gap = 0;
    gaps_on = 1'b1;
    gen_lvl = '0;
    tick_span = 16;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Reset value of the hold time, then idle-state corner cases
    check_hold_reg();
    add_item(FUNC_TAKE, 1'b0, 1'b0);
    add_item(FUNC_TICK, 1'b1, 1'b0);
    add_item(FUNC_SPARE, 1'b1, 1'b1);
    add_item(FUNC_LEVEL, 1'b0, 1'b0);
    // Overlapping presses: the any-button follows the first press and last release
    add_item(FUNC_LEVEL, 1'b1, 1'b1);
    add_item(FUNC_LEVEL, 1'b0, 1'b1);
    add_item(FUNC_TICK, 1'b0, 1'b1);
    add_item(FUNC_LEVEL, 1'b1, 1'b0);
    add_item(FUNC_TAKE, 1'b1, 1'b1);
    add_item(FUNC_TAKE, 1'b0, 1'b0);
    add_item(FUNC_LEVEL, 1'b0, 1'b0);
    add_item(FUNC_TAKE, 1'b0, 1'b0);
    wait_idle();

    // Zero hold time acts as one tick
    set_hold('0);
    add_item(FUNC_LEVEL, 1'b0, 1'b1);
    add_item(FUNC_TICK, 1'b0, 1'b0);
    add_item(FUNC_TICK, 1'b1, 1'b1);
    add_item(FUNC_TAKE, 1'b0, 1'b0);
    add_item(FUNC_LEVEL, 1'b1, 1'b1);
    add_item(FUNC_TICK, 1'b0, 1'b0);
    add_item(FUNC_LEVEL, 1'b0, 1'b0);
    add_item(FUNC_LEVEL, 1'b1, 1'b0);
    add_item(FUNC_TAKE, 1'b0, 1'b0);
    wait_idle();

    // Random phases over a spread of hold times
    settings = '{16'd1, 16'd65535, 16'd2, 16'd3, 16'd0, 16'd1000, 16'd5, 16'd4};
    settings[6] = hold_cnt_t'($urandom_range(4, 12));
    for (int p = 0; p < 8; p++) begin
      set_hold(settings[p]);
      gaps_on = (p != 2) && ($urandom_range(0, 3) != 0);
      add_random(RANDOM_ITEMS);
      wait_idle();
    end

    if (fail_count == 0 && events_due.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- files.f -----
sv/bhd_pkg.sv
sv/bhd_in_if.sv
sv/bhd_out_if.sv
sv/button_event_hold_detector.sv
sv/bhd_checker.sv
tb/sv/button_event_hold_detector_tb.sv
